>>> design/round_robin_slot_scheduler_top_defines.svh
// Assertion macros shared by the round-robin slot scheduler RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ROUND_ROBIN_SLOT_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_SLOT_SCHEDULER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRSS_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRSS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);

`endif

>>> design/rrss_pkg.sv
// Package for the round-robin slot scheduler: widths, codes, controller states
// and the command and status structs between controller and datapath. No dependencies.
package rrss_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int SLICE_W       = 10;
	localparam int STATUS_W      = 2;
	localparam int SLOT_OUT_W    = 3;
	localparam int CREATED_OUT_W = 4;
	localparam int SWITCH_W      = 32;

	localparam logic [SLICE_W-1:0] SLICE_RESET = 10'd10;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_STACK = 2'd2;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_CREATE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_APPLY,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic scan;
		logic apply;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic eval_exit;
		logic scan_end;
	} stat_t;

endpackage

>>> design/rrss_ctrl.sv
// Controller state machine of the round-robin slot scheduler.
// Depends on rrss_pkg; drives the datapath through rrss_pkg::cmd_t.
module rrss_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  rrss_pkg::stat_t stat,
	output logic            busy,
	output rrss_pkg::cmd_t  cmd
);

	rrss_pkg::state_t state_q;
	rrss_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrss_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			rrss_pkg::ST_IDLE: begin
				if (start) begin
					state_nx = rrss_pkg::ST_EVAL;
				end
			end
			rrss_pkg::ST_EVAL: begin
				if (stat.eval_exit) begin
					state_nx = rrss_pkg::ST_FINISH;
				end else begin
					state_nx = rrss_pkg::ST_SCAN;
				end
			end
			rrss_pkg::ST_SCAN: begin
				if (stat.scan_end) begin
					state_nx = rrss_pkg::ST_APPLY;
				end
			end
			rrss_pkg::ST_APPLY: begin
				state_nx = rrss_pkg::ST_FINISH;
			end
			rrss_pkg::ST_FINISH: begin
				state_nx = rrss_pkg::ST_IDLE;
			end
			default: begin
				state_nx = rrss_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			rrss_pkg::ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			rrss_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
			end
			rrss_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			rrss_pkg::ST_APPLY: begin
				cmd.apply = 1'b1;
			end
			rrss_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

>>> design/rrss_dp.sv
// Datapath of the round-robin slot scheduler: slot table, counters, scan and results.
// Depends on rrss_pkg and the assertion macros in round_robin_slot_scheduler_top_defines.svh.
`include "round_robin_slot_scheduler_top_defines.svh"

module rrss_dp #(
	parameter int NUM_SLOTS = rrss_pkg::NUM_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rrss_pkg::cmd_t                       cmd,
	output rrss_pkg::stat_t                      stat,
	input  logic                                 opcode,
	input  logic                                 stack_ok,
	input  logic                                 cfg_we,
	input  logic [rrss_pkg::SLICE_W-1:0]         cfg_data,
	output logic                                 done,
	output logic [rrss_pkg::STATUS_W-1:0]        status,
	output logic [rrss_pkg::SLOT_OUT_W-1:0]      new_slot,
	output logic                                 switched,
	output logic [rrss_pkg::SLOT_OUT_W-1:0]      running_slot,
	output logic [rrss_pkg::SLOT_OUT_W-1:0]      previous_slot,
	output logic [rrss_pkg::SWITCH_W-1:0]        switch_total,
	output logic [rrss_pkg::CREATED_OUT_W-1:0]   created_total
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
	localparam int SLOT_X = SLOT_W + rrss_pkg::SLOT_OUT_W;
	localparam int CNT_X  = CNT_W + rrss_pkg::CREATED_OUT_W;

	logic [NUM_SLOTS-1:0]              live_q;
	logic [SLOT_W-1:0]                 cur_q;
	logic [rrss_pkg::SLICE_W-1:0]      ticks_q;
	logic [CNT_W-1:0]                  created_q;
	logic [rrss_pkg::SWITCH_W-1:0]     switch_q;
	logic [rrss_pkg::SLICE_W-1:0]      slice_q;
	logic                              done_q;

	logic                              op_q;
	logic                              stack_q;
	logic [SLOT_W-1:0]                 prev_q;
	logic [SLOT_W-1:0]                 idx_q;
	logic [CNT_W-1:0]                  left_q;
	logic [SLOT_W-1:0]                 found_q;
	logic                              hit_q;
	logic [rrss_pkg::STATUS_W-1:0]     status_q;
	logic [SLOT_W-1:0]                 new_slot_q;
	logic                              switched_q;

	logic [rrss_pkg::STATUS_W-1:0]     res_status_q;
	logic [rrss_pkg::SLOT_OUT_W-1:0]   res_new_slot_q;
	logic                              res_switched_q;
	logic [rrss_pkg::SLOT_OUT_W-1:0]   res_running_q;
	logic [rrss_pkg::SLOT_OUT_W-1:0]   res_previous_q;
	logic [rrss_pkg::SWITCH_W-1:0]     res_switch_q;
	logic [rrss_pkg::CREATED_OUT_W-1:0] res_created_q;

	logic [rrss_pkg::SLICE_W-1:0]      ticks_nx;
	logic                              expired;
	logic                              table_full;
	logic                              is_create;
	logic                              want;
	logic [SLOT_W-1:0]                 cur_inc;
	logic [SLOT_W-1:0]                 idx_inc;
	logic [SLOT_X-1:0]                 new_slot_x;
	logic [SLOT_X-1:0]                 cur_x;
	logic [SLOT_X-1:0]                 prev_x;
	logic [CNT_X-1:0]                  created_x;

	assign is_create  = (op_q == rrss_pkg::OP_CREATE);
	assign ticks_nx   = ticks_q + rrss_pkg::SLICE_W'(1);
	assign expired    = (ticks_nx >= slice_q);
	assign table_full = (created_q >= CNT_W'(NUM_SLOTS));
	assign cur_inc    = (cur_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : cur_q + SLOT_W'(1);
	assign idx_inc    = (idx_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : idx_q + SLOT_W'(1);
	assign want       = is_create ? !live_q[idx_q] : live_q[idx_q];

	assign stat.eval_exit = is_create ? (table_full || !stack_q) : !expired;
	assign stat.scan_end  = want || (left_q == CNT_W'(1));

	assign new_slot_x = SLOT_X'(new_slot_q);
	assign cur_x      = SLOT_X'(cur_q);
	assign prev_x     = SLOT_X'(prev_q);
	assign created_x  = CNT_X'(created_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			cur_q     <= '0;
			ticks_q   <= '0;
			created_q <= '0;
			switch_q  <= '0;
			slice_q   <= rrss_pkg::SLICE_RESET;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cfg_we) begin
				slice_q <= cfg_data;
			end
			if (cmd.eval && !is_create) begin
				ticks_q <= ticks_nx;
			end
			if (cmd.apply) begin
				if (is_create) begin
					if (hit_q) begin
						live_q[found_q] <= 1'b1;
						created_q       <= created_q + CNT_W'(1);
						if (found_q == cur_q) begin
							ticks_q <= '0;
						end
					end
				end else begin
					ticks_q <= '0;
					if (hit_q) begin
						switch_q <= switch_q + rrss_pkg::SWITCH_W'(1);
						cur_q    <= found_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= opcode;
			stack_q <= stack_ok;
			prev_q  <= cur_q;
		end
		if (cmd.eval) begin
			hit_q      <= 1'b0;
			new_slot_q <= '0;
			switched_q <= 1'b0;
			if (is_create) begin
				idx_q  <= '0;
				left_q <= CNT_W'(NUM_SLOTS);
				if (table_full) begin
					status_q <= rrss_pkg::STATUS_FULL;
				end else if (!stack_q) begin
					status_q <= rrss_pkg::STATUS_STACK;
				end else begin
					status_q <= rrss_pkg::STATUS_OK;
				end
			end else begin
				idx_q    <= cur_inc;
				left_q   <= CNT_W'(NUM_SLOTS - 1);
				status_q <= rrss_pkg::STATUS_OK;
			end
		end
		if (cmd.scan) begin
			if (want) begin
				hit_q   <= 1'b1;
				found_q <= idx_q;
			end else begin
				idx_q  <= idx_inc;
				left_q <= left_q - CNT_W'(1);
			end
		end
		if (cmd.apply) begin
			if (is_create) begin
				if (hit_q) begin
					new_slot_q <= found_q;
				end else begin
					status_q <= rrss_pkg::STATUS_FULL;
				end
			end else begin
				switched_q <= hit_q;
			end
		end
		if (cmd.finish) begin
			res_status_q   <= status_q;
			res_new_slot_q <= new_slot_x[rrss_pkg::SLOT_OUT_W-1:0];
			res_switched_q <= switched_q;
			res_running_q  <= cur_x[rrss_pkg::SLOT_OUT_W-1:0];
			res_previous_q <= prev_x[rrss_pkg::SLOT_OUT_W-1:0];
			res_switch_q   <= switch_q;
			res_created_q  <= created_x[rrss_pkg::CREATED_OUT_W-1:0];
		end
	end

	assign done          = done_q;
	assign status        = res_status_q;
	assign new_slot      = res_new_slot_q;
	assign switched      = res_switched_q;
	assign running_slot  = res_running_q;
	assign previous_slot = res_previous_q;
	assign switch_total  = res_switch_q;
	assign created_total = res_created_q;

	`RRSS_ASSERT_SAME(a_created_matches_live, 1'b1, $countones(live_q) == int'(created_q), "created count differs from live slots")
	`RRSS_ASSERT_SAME(a_created_bound, 1'b1, created_q <= CNT_W'(NUM_SLOTS), "created count exceeds slot count")
	`RRSS_ASSERT_SAME(a_claim_dead_slot, cmd.apply && is_create && hit_q, !live_q[found_q], "create claims a live slot")
	`RRSS_ASSERT_SAME(a_switch_moves, cmd.finish && switched_q, cur_q != prev_q, "switch kept the same slot")
	`RRSS_ASSERT_NEXT(a_strobe_single, done_q, !done_q, "result strobe longer than one cycle")

endmodule

>>> design/round_robin_slot_scheduler_top.sv
// Top level of the round-robin slot scheduler.
// Depends on rrss_pkg, rrss_ctrl and rrss_dp.
//
// Usage: raise start with opcode and stack_ok; the transaction is accepted at a
// rising edge where start is high and busy is low. Opcode tick counts time for
// the current slot; opcode create claims the lowest dead slot.
// Each transaction yields one result, shown on the result ports for exactly one
// cycle with done high. The receiver cannot stall; results are never held back.
// A tick whose slice has not expired and a create that fails go from accept
// through EVAL and FINISH to the done cycle; when a scan runs, SCAN and APPLY
// come between EVAL and FINISH, and the scan visits 1 to NUM_SLOTS slots.
// The scan visits one slot per cycle in the datapath. busy stays high until
// the controller is back in IDLE, so a new transaction waits for the last one.
// time_slice is written via cfg_valid/cfg_data, always ready; the user must write
// it only while no transaction is in flight; the block itself does not enforce it.
// Reset (arst_n low) makes all slots dead, clears the current slot, tick,
// created and switch counters, and sets time_slice to 10. No clearing pass.
module round_robin_slot_scheduler_top #(
	parameter int NUM_SLOTS = rrss_pkg::NUM_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 opcode,
	input  logic                                 stack_ok,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rrss_pkg::SLICE_W-1:0]         cfg_data,
	output logic                                 done,
	output logic [rrss_pkg::STATUS_W-1:0]        status,
	output logic [rrss_pkg::SLOT_OUT_W-1:0]      new_slot,
	output logic                                 switched,
	output logic [rrss_pkg::SLOT_OUT_W-1:0]      running_slot,
	output logic [rrss_pkg::SLOT_OUT_W-1:0]      previous_slot,
	output logic [rrss_pkg::SWITCH_W-1:0]        switch_total,
	output logic [rrss_pkg::CREATED_OUT_W-1:0]   created_total
);

	rrss_pkg::cmd_t  cmd;
	rrss_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	rrss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	rrss_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.opcode        (opcode),
		.stack_ok      (stack_ok),
		.cfg_we        (cfg_valid),
		.cfg_data      (cfg_data),
		.done          (done),
		.status        (status),
		.new_slot      (new_slot),
		.switched      (switched),
		.running_slot  (running_slot),
		.previous_slot (previous_slot),
		.switch_total  (switch_total),
		.created_total (created_total)
	);

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for round_robin_slot_scheduler_top: directed table, then random phases.
// Keeps its own model of the slot table to predict each result.
// Depends on rrss_pkg and the scheduler RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rrss_pkg::*;

	localparam int NUM_SLOTS = NUM_SLOTS_DEF;
	localparam int PHASE_ITEMS = 250;

	typedef enum logic [1:0] {
		SLOT_DEAD,
		SLOT_READY,
		SLOT_RUNNING
	} slot_state_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic [SLOT_OUT_W-1:0]    new_slot;
		logic                     switched;
		logic [SLOT_OUT_W-1:0]    running_slot;
		logic [SLOT_OUT_W-1:0]    previous_slot;
		logic [SWITCH_W-1:0]      switch_total;
		logic [CREATED_OUT_W-1:0] created_total;
	} sched_result_t;

	typedef struct packed {
		row_kind_t           kind;
		logic                op;
		logic                sok;
		logic [SLICE_W-1:0]  slice;
		logic                typed;
		sched_result_t       want;
	} row_t;

	localparam sched_result_t FROM_MODEL = '0;

	localparam row_t DIRECTED_ROWS [0:21] = '{
		'{ROW_CFG,  OP_TICK,   1'b0, 10'd1,    1'b0, FROM_MODEL},
		'{ROW_ITEM, OP_TICK,   1'b0, 10'd0,    1'b1, '{STATUS_OK, 0, 0, 0, 0, 0, 0}},
		'{ROW_ITEM, OP_CREATE, 1'b0, 10'd0,    1'b1, '{STATUS_STACK, 0, 0, 0, 0, 0, 0}},
		'{ROW_ITEM, OP_CREATE, 1'b1, 10'd0,    1'b1, '{STATUS_OK, 0, 0, 0, 0, 0, 1}},
		'{ROW_ITEM, OP_TICK,   1'b0, 10'd0,    1'b1, '{STATUS_OK, 0, 0, 0, 0, 0, 1}},
		'{ROW_ITEM, OP_CREATE, 1'b1, 10'd0,    1'b1, '{STATUS_OK, 1, 0, 0, 0, 0, 2}},
		'{ROW_ITEM, OP_TICK,   1'b1, 10'd0,    1'b0, FROM_MODEL},
		'{ROW_ITEM, OP_CREATE, 1'b1, 10'd0,    1'b0, FROM_MODEL},
		'{ROW_ITEM, OP_TICK,   1'b0, 10'd0,    1'b0, FROM_MODEL},
		'{ROW_ITEM, OP_TICK,   1'b1, 10'd0,    1'b0, FROM_MODEL},
		'{ROW_CFG,  OP_TICK,   1'b0, 10'd1023, 1'b0, FROM_MODEL},
		'{ROW_ITEM, OP_TICK,   1'b0, 10'd0,    1'b0, FROM_MODEL},
		'{ROW_ITEM, OP_TICK,   1'b1, 10'd0,    1'b0, FROM_MODEL},
		'{ROW_CFG,  OP_TICK,   1'b0, 10'd0,    1'b0, FROM_MODEL},
		'{ROW_ITEM, OP_TICK,   1'b0, 10'd0,    1'b0, FROM_MODEL},
		'{ROW_ITEM, OP_CREATE, 1'b1, 10'd0,    1'b0, FROM_MODEL},
		'{ROW_ITEM, OP_CREATE, 1'b1, 10'd0,    1'b0, FROM_MODEL},
		'{ROW_ITEM, OP_CREATE, 1'b1, 10'd0,    1'b0, FROM_MODEL},
		'{ROW_ITEM, OP_CREATE, 1'b1, 10'd0,    1'b0, FROM_MODEL},
		'{ROW_ITEM, OP_CREATE, 1'b1, 10'd0,    1'b0, FROM_MODEL},
		'{ROW_ITEM, OP_CREATE, 1'b1, 10'd0,    1'b1, '{STATUS_FULL, 0, 0, 1, 1, 4, 8}},
		'{ROW_ITEM, OP_CREATE, 1'b0, 10'd0,    1'b1, '{STATUS_FULL, 0, 0, 1, 1, 4, 8}}
	};

	localparam logic [SLICE_W-1:0] PHASE_SLICE [0:7] = '{1, 3, 1023, 2, 12, 1023, 5, 1};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic                     opcode = OP_TICK;
	logic                     stack_ok = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [SLICE_W-1:0]       cfg_data = '0;
	logic                     done;
	logic [STATUS_W-1:0]      status;
	logic [SLOT_OUT_W-1:0]    new_slot;
	logic                     switched;
	logic [SLOT_OUT_W-1:0]    running_slot;
	logic [SLOT_OUT_W-1:0]    previous_slot;
	logic [SWITCH_W-1:0]      switch_total;
	logic [CREATED_OUT_W-1:0] created_total;

	slot_state_t              slot_state [NUM_SLOTS];
	logic [SLOT_OUT_W-1:0]    cur_slot;
	logic [SLICE_W-1:0]       tick_cnt;
	logic [SLICE_W-1:0]       slice_len;
	logic [CREATED_OUT_W-1:0] created_cnt;
	logic [SWITCH_W-1:0]      switch_cnt;

	sched_result_t            pending_results [$];
	int                       errors = 0;

	round_robin_slot_scheduler_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.stack_ok      (stack_ok),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.status        (status),
		.new_slot      (new_slot),
		.switched      (switched),
		.running_slot  (running_slot),
		.previous_slot (previous_slot),
		.switch_total  (switch_total),
		.created_total (created_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic sched_result_t schedule_item(input logic op, input logic sok);
		sched_result_t r;
		int free_slot;
		int nxt;
		int i;
		r = '0;
		r.previous_slot = cur_slot;
		if (op == OP_CREATE) begin
			free_slot = NUM_SLOTS;
			for (i = NUM_SLOTS - 1; i >= 0; i--) begin
				if (slot_state[i] == SLOT_DEAD)
					free_slot = i;
			end
			if (created_cnt >= NUM_SLOTS || free_slot >= NUM_SLOTS) begin
				r.status = STATUS_FULL;
			end else if (!sok) begin
				r.status = STATUS_STACK;
			end else begin
				slot_state[free_slot] = SLOT_READY;
				if (free_slot == cur_slot)
					tick_cnt = '0;
				created_cnt = created_cnt + 1'b1;
				r.new_slot = free_slot[SLOT_OUT_W-1:0];
			end
		end else begin
			tick_cnt = tick_cnt + 1'b1;
			if (tick_cnt >= slice_len) begin
				nxt = int'(cur_slot);
				for (i = 0; i < NUM_SLOTS; i++) begin
					nxt = (nxt + 1) % NUM_SLOTS;
					if (slot_state[nxt] == SLOT_READY || slot_state[nxt] == SLOT_RUNNING)
						break;
				end
				tick_cnt = '0;
				if (nxt != cur_slot) begin
					switch_cnt = switch_cnt + 1'b1;
					if (slot_state[cur_slot] != SLOT_DEAD)
						slot_state[cur_slot] = SLOT_READY;
					slot_state[nxt] = SLOT_RUNNING;
					cur_slot = nxt[SLOT_OUT_W-1:0];
					r.switched = 1'b1;
				end
			end
		end
		r.running_slot = cur_slot;
		r.switch_total = switch_cnt;
		r.created_total = created_cnt;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: status %0d running_slot %0d",
					$time, status, running_slot);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("new_slot", 32'(want.new_slot), 32'(new_slot));
				check_field("switched", 32'(want.switched), 32'(switched));
				check_field("running_slot", 32'(want.running_slot), 32'(running_slot));
				check_field("previous_slot", 32'(want.previous_slot), 32'(previous_slot));
				check_field("switch_total", want.switch_total, switch_total);
				check_field("created_total", 32'(want.created_total), 32'(created_total));
			end
		end
	end

	task automatic send_item(input logic op, input logic sok, input int idle_pct,
		input logic use_fixed, input sched_result_t fixed);
		sched_result_t predicted;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		stack_ok <= sok;
		do @(posedge clk); while (busy);
		predicted = schedule_item(op, sok);
		pending_results.push_back(use_fixed ? fixed : predicted);
	endtask

	task automatic write_slice(input logic [SLICE_W-1:0] value);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		slice_len = value;
	endtask

	initial begin
		int idle_pct;
		logic op;
		foreach (slot_state[i])
			slot_state[i] = SLOT_DEAD;
		cur_slot = '0;
		tick_cnt = '0;
		created_cnt = '0;
		switch_cnt = '0;
		slice_len = SLICE_RESET;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].kind == ROW_CFG)
				write_slice(DIRECTED_ROWS[i].slice);
			else
				send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].sok, 30,
					DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		end

		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 4)
				write_slice(SLICE_W'($urandom_range(4, 20)));
			else
				write_slice(PHASE_SLICE[phase]);
			idle_pct = (phase == 7) ? 0 : 30 * $urandom_range(0, 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = ($urandom_range(0, 9) == 0) ? OP_CREATE : OP_TICK;
				send_item(op, 1'($urandom_range(0, 1)), idle_pct, 1'b0, FROM_MODEL);
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/rrss_pkg.sv
design/rrss_ctrl.sv
design/rrss_dp.sv
design/round_robin_slot_scheduler_top.sv
tb/sv/testbench.sv
